// ===== rtl/rifp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio indication frame parser package
// Shared types, symbol constants and the opcode decode for the parser blocks.
// ----------------------------------------------------------------------------
package rifp_pkg;

	// Frame symbols.
	localparam logic [7:0] SYM_STX      = 8'h02;
	localparam logic [7:0] SYM_IND      = 8'h69;
	localparam logic [7:0] OP_READY     = 8'h25;
	localparam logic [7:0] OP_LINK_UP   = 8'h0C;
	localparam logic [7:0] OP_TRANSP    = 8'h11;
	localparam logic [7:0] OP_LINK_DOWN = 8'h0E;
	localparam logic [7:0] SYM_ETX      = 8'h03;

	// Reported indication codes.
	typedef enum logic [2:0] {
		IND_NONE      = 3'd0,
		IND_READY     = 3'd1,
		IND_LINK_UP   = 3'd2,
		IND_TRANSP    = 3'd3,
		IND_LINK_DOWN = 3'd4
	} ind_t;

	// Link status codes.
	typedef enum logic [1:0] {
		LINK_UNINIT = 2'd0,
		LINK_IDLE   = 2'd1,
		LINK_CONN   = 2'd2
	} link_t;

	// Frame recognizer phases.
	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_TYPE   = 3'd1,
		PH_OPCODE = 3'd2,
		PH_LEN_LO = 3'd3,
		PH_LEN_HI = 3'd4,
		PH_CHECK  = 3'd5,
		PH_DATA   = 3'd6,
		PH_END    = 3'd7
	} phase_t;

	// Maps an opcode byte to its indication code; unknown opcodes give none.
	function automatic ind_t opcode_code(input logic [7:0] b);
		ind_t code;
		case (b)
			OP_READY:     code = IND_READY;
			OP_LINK_UP:   code = IND_LINK_UP;
			OP_TRANSP:    code = IND_TRANSP;
			OP_LINK_DOWN: code = IND_LINK_DOWN;
			default:      code = IND_NONE;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/rifp_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame recognizer
// Walks the STX / type / opcode / length / checksum / payload / ETX sequence
// one word per cycle while advance is high, and reports the opcode's indication on a good ETX.
// ----------------------------------------------------------------------------
module rifp_frame_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          rx_byte,
	output rifp_pkg::ind_t      ind
);

	rifp_pkg::phase_t phase_q, phase_d;
	rifp_pkg::ind_t   kind_q, kind_d;
	logic [7:0]       sum_q, sum_d;
	logic [15:0]      left_q, left_d;
	rifp_pkg::ind_t   code;

	assign code = rifp_pkg::opcode_code(rx_byte);

	// Next-state logic for the recognizer and its frame context.
	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		sum_d   = sum_q;
		left_d  = left_q;
		case (phase_q)
			rifp_pkg::PH_START: begin
				if (rx_byte == rifp_pkg::SYM_STX) phase_d = rifp_pkg::PH_TYPE;
			end
			rifp_pkg::PH_TYPE: begin
				phase_d = (rx_byte == rifp_pkg::SYM_IND) ? rifp_pkg::PH_OPCODE
				                                         : rifp_pkg::PH_START;
			end
			rifp_pkg::PH_OPCODE: begin
				if (code != rifp_pkg::IND_NONE) begin
					kind_d  = code;
					sum_d   = rifp_pkg::SYM_IND + rx_byte;
					phase_d = rifp_pkg::PH_LEN_LO;
				end else begin
					phase_d = rifp_pkg::PH_START;
				end
			end
			rifp_pkg::PH_LEN_LO: begin
				left_d  = {8'h00, rx_byte};
				sum_d   = sum_q + rx_byte;
				phase_d = rifp_pkg::PH_LEN_HI;
			end
			rifp_pkg::PH_LEN_HI: begin
				left_d  = {rx_byte, left_q[7:0]};
				sum_d   = sum_q + rx_byte;
				phase_d = rifp_pkg::PH_CHECK;
			end
			rifp_pkg::PH_CHECK: begin
				phase_d = (rx_byte == sum_q) ? rifp_pkg::PH_DATA : rifp_pkg::PH_START;
			end
			rifp_pkg::PH_DATA: begin
				// A zero length still skips one payload word.
				if (left_q <= 16'd1) phase_d = rifp_pkg::PH_END;
				left_d = left_q - 16'd1;
			end
			rifp_pkg::PH_END: begin
				phase_d = rifp_pkg::PH_START;
			end
			default: begin
				phase_d = rifp_pkg::PH_START;
			end
		endcase
	end

	// Output logic: the frame is reported when ETX closes it.
	always_comb begin
		ind = rifp_pkg::IND_NONE;
		if (phase_q == rifp_pkg::PH_END && rx_byte == rifp_pkg::SYM_ETX) ind = kind_q;
	end

	// State registers advance only on words that are parsed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rifp_pkg::PH_START;
			kind_q  <= rifp_pkg::IND_NONE;
			sum_q   <= 8'h00;
			left_q  <= 16'h0000;
		end else if (advance) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			sum_q   <= sum_d;
			left_q  <= left_d;
		end
	end

endmodule

// ===== rtl/rifp_link_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link status tracker
// Advances the link status on reported frames and requests a receive flush
// when the link comes up or goes down.
// ----------------------------------------------------------------------------
module rifp_link_tracker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  rifp_pkg::ind_t    ind,
	output rifp_pkg::link_t   status,
	output logic              flush
);

	rifp_pkg::link_t link_q;

	// Transition logic; status reflects the word currently presented.
	always_comb begin
		status = link_q;
		flush  = 1'b0;
		if (advance) begin
			case (link_q)
				rifp_pkg::LINK_UNINIT: begin
					if (ind == rifp_pkg::IND_READY) status = rifp_pkg::LINK_IDLE;
				end
				rifp_pkg::LINK_IDLE: begin
					if (ind == rifp_pkg::IND_LINK_UP) begin
						status = rifp_pkg::LINK_CONN;
						flush  = 1'b1;
					end
				end
				rifp_pkg::LINK_CONN: begin
					if (ind == rifp_pkg::IND_LINK_DOWN) begin
						status = rifp_pkg::LINK_IDLE;
						flush  = 1'b1;
					end
				end
				default: begin
					status = link_q;
				end
			endcase
		end
	end

	// Link status register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= rifp_pkg::LINK_UNINIT;
		end else begin
			link_q <= status;
		end
	end

endmodule

// ===== rtl/radio_indication_frame_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio indication frame parser unit
// Parses received serial words into radio indications and link status.
// ----------------------------------------------------------------------------
// Every accepted word yields exactly one result word, in the next cycle, from
// the result register. A word is accepted in every cycle unless the result
// register holds a word that is stalled, so the unit sustains one word per
// cycle while not stalled. Words flagged with a framing error or a full
// receive buffer produce indication none and the current link status with
// no other effect. flush_rx marks the result word at which the receive FIFO
// must be emptied.
// ----------------------------------------------------------------------------
module radio_indication_frame_parser_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       framing_error,
	input  logic       rx_full,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] indication,
	output logic [1:0] link_status,
	output logic       flush_rx
);

	logic            accept;
	logic            advance;
	rifp_pkg::ind_t  ind;
	rifp_pkg::link_t status;
	logic            flush;
	logic            out_valid_q;
	logic [2:0]      indication_q;
	logic [1:0]      link_status_q;
	logic            flush_rx_q;

	// Input side stalls only while a result is held back.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign advance  = accept && !framing_error && !rx_full;

	rifp_frame_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (rx_byte),
		.ind     (ind)
	);

	rifp_link_tracker u_link (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.ind     (advance ? ind : rifp_pkg::IND_NONE),
		.status  (status),
		.flush   (flush)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			indication_q  <= advance ? 3'(ind) : 3'(rifp_pkg::IND_NONE);
			link_status_q <= 2'(status);
			flush_rx_q    <= flush;
		end
	end

	assign out_valid   = out_valid_q;
	assign indication  = indication_q;
	assign link_status = link_status_q;
	assign flush_rx    = flush_rx_q;

	// A flush only accompanies a link up or link down indication.
	a_flush_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flush_rx |->
			indication == 3'(rifp_pkg::IND_LINK_UP) ||
			indication == 3'(rifp_pkg::IND_LINK_DOWN))
		else $error("flush without link change indication");

	// A dropped word reports nothing.
	a_drop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (framing_error || rx_full) |=>
			indication == 3'(rifp_pkg::IND_NONE) && !flush_rx)
		else $error("dropped word produced an indication");

	// Once a ready frame is reported the link is initialized.
	a_ready_init: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && indication == 3'(rifp_pkg::IND_READY) |->
			link_status != 2'(rifp_pkg::LINK_UNINIT))
		else $error("ready indication left link uninitialized");

	// The link leaves the uninitialized state only on a ready frame.
	a_init_cause: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ind != rifp_pkg::IND_READY &&
			$past(status) == rifp_pkg::LINK_UNINIT |->
			status == rifp_pkg::LINK_UNINIT)
		else $error("link initialized without ready frame");

endmodule
